// ----- sv/fcrd_pkg.sv -----
// Shared types and codes for the FastCGI record deframer.
// No dependencies; imported by every module of the block.
`default_nettype none
package fcrd_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] CFG_PAIR_TYPE = 8'd0;
  localparam logic [7:0] CFG_PAIR_EN   = 8'd1;

  localparam logic [7:0] PAIR_TYPE_RESET = 8'd4;
  localparam logic       PAIR_EN_RESET   = 1'b1;

  localparam logic [1:0] FR_HEADER  = 2'd0;
  localparam logic [1:0] FR_CONTENT = 2'd1;
  localparam logic [1:0] FR_PADDING = 2'd2;

  localparam logic [2:0] CLS_HEADER  = 3'd0;
  localparam logic [2:0] CLS_CONTENT = 3'd1;
  localparam logic [2:0] CLS_PADDING = 3'd2;
  localparam logic [2:0] CLS_NLEN    = 3'd3;
  localparam logic [2:0] CLS_VLEN    = 3'd4;
  localparam logic [2:0] CLS_NAME    = 3'd5;
  localparam logic [2:0] CLS_VALUE   = 3'd6;

  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  frame;
    logic        hd;
    logic        rend;
    logic        last;
    logic        decode;
    logic [55:0] hdr;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       wr;
    logic [7:0] index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage
`default_nettype wire

// ----- sv/fcrd_front.sv -----
// Front end: accepts bytes, tracks header/content/padding framing, holds config.
// Depends on fcrd_pkg; feeds fcrd_queue.
`default_nettype none
module fcrd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire fcrd_pkg::cfg_wr_t cfg_i,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire fcrd_pkg::q_stat_t q_stat_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output fcrd_pkg::entry_t     entry_o
);
  import fcrd_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [55:0] hdr_q, hdr_d;
  logic [15:0] cl_q, cl_d;
  logic [7:0]  pl_q, pl_d;
  logic [7:0]  pair_type_q;
  logic        pair_en_q;
  logic        hd, rend, last;

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    hdr_d   = hdr_q;
    cl_d    = cl_q;
    pl_d    = pl_q;
    hd      = 1'b0;
    rend    = 1'b0;
    last    = 1'b0;
    case (phase_q)
      FR_CONTENT: begin
        cl_d = (cl_q != 16'd0) ? cl_q - 16'd1 : cl_q;
        if (cl_d == 16'd0) begin
          last = 1'b1;
          if (pl_q != 8'd0) begin
            phase_d = FR_PADDING;
          end else begin
            rend    = 1'b1;
            phase_d = FR_HEADER;
          end
        end
      end
      FR_PADDING: begin
        pl_d = (pl_q != 8'd0) ? pl_q - 8'd1 : pl_q;
        if (pl_d == 8'd0) begin
          rend    = 1'b1;
          phase_d = FR_HEADER;
        end
      end
      default: begin
        if (idx_q != 3'd7) begin
          hdr_d[8*idx_q +: 8] = data_byte_i;
          idx_d   = idx_q + 3'd1;
          phase_d = FR_HEADER;
        end else begin
          hd    = 1'b1;
          idx_d = 3'd0;
          cl_d  = {hdr_q[39:32], hdr_q[47:40]};
          pl_d  = hdr_q[55:48];
          if (cl_d != 16'd0) begin
            phase_d = FR_CONTENT;
          end else if (pl_d != 8'd0) begin
            phase_d = FR_PADDING;
          end else begin
            rend    = 1'b1;
            phase_d = FR_HEADER;
          end
        end
      end
    endcase
  end

  always_comb begin
    entry_o.data   = data_byte_i;
    entry_o.frame  = (phase_q == FR_CONTENT || phase_q == FR_PADDING) ? phase_q : FR_HEADER;
    entry_o.hd     = hd;
    entry_o.rend   = rend;
    entry_o.last   = last;
    entry_o.decode = pair_en_q && (hdr_q[15:8] == pair_type_q);
    entry_o.hdr    = hdr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= FR_HEADER;
      idx_q   <= 3'd0;
      hdr_q   <= 56'd0;
      cl_q    <= 16'd0;
      pl_q    <= 8'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      hdr_q   <= hdr_d;
      cl_q    <= cl_d;
      pl_q    <= pl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_type_q <= PAIR_TYPE_RESET;
      pair_en_q   <= PAIR_EN_RESET;
    end else if (cfg_i.wr) begin
      case (cfg_i.index)
        CFG_PAIR_TYPE: pair_type_q <= cfg_i.data;
        CFG_PAIR_EN:   pair_en_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/fcrd_queue.sv -----
// Short in-order queue between the framing front end and the pair decoder.
// Depends on fcrd_pkg for the entry type.
`default_nettype none
module fcrd_queue #(
  parameter int unsigned Depth = fcrd_pkg::QueueDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire fcrd_pkg::entry_t entry_i,
  input  wire logic             pop_i,
  output fcrd_pkg::entry_t      head_o,
  output fcrd_pkg::q_stat_t     stat_o
);
  import fcrd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/fcrd_back.sv -----
// Back end: name-value pair decoding of content bytes and the output register.
// Depends on fcrd_pkg; drains fcrd_queue.
`default_nettype none
module fcrd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fcrd_pkg::entry_t head_i,
  input  wire fcrd_pkg::q_stat_t q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [2:0]            byte_class_o,
  output logic [7:0]            byte_out_o,
  output logic                  header_done_o,
  output logic [7:0]            proto_version_o,
  output logic [7:0]            record_kind_o,
  output logic [15:0]           req_ident_o,
  output logic [15:0]           body_length_o,
  output logic [7:0]            pad_length_o,
  output logic [30:0]           pair_name_length_o,
  output logic [30:0]           pair_value_length_o,
  output logic                  record_end_o,
  output logic                  pair_overrun_o
);
  import fcrd_pkg::*;

  localparam logic [2:0] PP_NLEN      = 3'd0;
  localparam logic [2:0] PP_NLEN_MORE = 3'd1;
  localparam logic [2:0] PP_VLEN      = 3'd2;
  localparam logic [2:0] PP_VLEN_MORE = 3'd3;
  localparam logic [2:0] PP_NAME      = 3'd4;
  localparam logic [2:0] PP_VALUE     = 3'd5;

  logic [2:0]  pp_q, pp_d;
  logic [30:0] acc_q, acc_d, name_q, name_d, value_q, value_d;
  logic [1:0]  lbl_q, lbl_d, lbl_eff;
  logic [30:0] shifted, acc_new, cnt_dec;
  logic [30:0] nl, vl;
  logic [2:0]  cls;
  logic        ovr, is_vlen, out_valid_q;

  function automatic logic [2:0] after_lengths(input logic [30:0] n, input logic [30:0] v);
    if (n != 31'd0) return PP_NAME;
    if (v != 31'd0) return PP_VALUE;
    return PP_NLEN;
  endfunction

  assign pop_o       = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    pp_d    = pp_q;
    acc_d   = acc_q;
    name_d  = name_q;
    value_d = value_q;
    lbl_d   = lbl_q;
    lbl_eff = lbl_q;
    shifted = 31'd0;
    acc_new = acc_q;
    cnt_dec = 31'd0;
    nl      = 31'd0;
    vl      = 31'd0;
    is_vlen = 1'b0;
    case (head_i.frame)
      FR_CONTENT: cls = CLS_CONTENT;
      FR_PADDING: cls = CLS_PADDING;
      default:    cls = CLS_HEADER;
    endcase
    if (head_i.frame == FR_CONTENT && head_i.decode) begin
      case (pp_q)
        PP_NLEN_MORE, PP_VLEN_MORE: begin
          is_vlen = (pp_q == PP_VLEN_MORE);
          cls     = is_vlen ? CLS_VLEN : CLS_NLEN;
          lbl_eff = (lbl_q == 2'd0) ? 2'd1 : lbl_q;
          case (lbl_eff)
            2'd3:    shifted = {7'd0, head_i.data, 16'd0};
            2'd2:    shifted = {15'd0, head_i.data, 8'd0};
            default: shifted = {23'd0, head_i.data};
          endcase
          acc_new = acc_q | shifted;
          acc_d   = acc_new;
          lbl_d   = lbl_eff - 2'd1;
          if (lbl_d == 2'd0) begin
            if (is_vlen) begin
              value_d = acc_new;
              vl      = acc_new;
              pp_d    = after_lengths(name_q, acc_new);
            end else begin
              name_d = acc_new;
              nl     = acc_new;
              pp_d   = PP_VLEN;
            end
          end
        end
        PP_NAME: begin
          cls     = CLS_NAME;
          cnt_dec = (name_q != 31'd0) ? name_q - 31'd1 : name_q;
          name_d  = cnt_dec;
          if (cnt_dec == 31'd0) begin
            pp_d = (value_q != 31'd0) ? PP_VALUE : PP_NLEN;
          end
        end
        PP_VALUE: begin
          cls     = CLS_VALUE;
          cnt_dec = (value_q != 31'd0) ? value_q - 31'd1 : value_q;
          value_d = cnt_dec;
          if (cnt_dec == 31'd0) begin
            pp_d = PP_NLEN;
          end
        end
        default: begin
          is_vlen = (pp_q == PP_VLEN);
          cls     = is_vlen ? CLS_VLEN : CLS_NLEN;
          if (head_i.data[7]) begin
            acc_d = {head_i.data[6:0], 24'd0};
            lbl_d = 2'd3;
            pp_d  = is_vlen ? PP_VLEN_MORE : PP_NLEN_MORE;
          end else if (is_vlen) begin
            value_d = {23'd0, head_i.data};
            vl      = {23'd0, head_i.data};
            pp_d    = after_lengths(name_q, {23'd0, head_i.data});
          end else begin
            name_d = {23'd0, head_i.data};
            nl     = {23'd0, head_i.data};
            pp_d   = PP_VLEN;
          end
        end
      endcase
    end
    ovr = head_i.last && head_i.decode && (pp_d != PP_NLEN);
    if (head_i.hd) begin
      pp_d    = PP_NLEN;
      acc_d   = 31'd0;
      lbl_d   = 2'd0;
      name_d  = 31'd0;
      value_d = 31'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q        <= PP_NLEN;
      acc_q       <= 31'd0;
      lbl_q       <= 2'd0;
      name_q      <= 31'd0;
      value_q     <= 31'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pp_q    <= pp_d;
        acc_q   <= acc_d;
        lbl_q   <= lbl_d;
        name_q  <= name_d;
        value_q <= value_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_class_o        <= cls;
      byte_out_o          <= head_i.data;
      header_done_o       <= head_i.hd;
      proto_version_o     <= head_i.hdr[7:0];
      record_kind_o       <= head_i.hdr[15:8];
      req_ident_o         <= {head_i.hdr[23:16], head_i.hdr[31:24]};
      body_length_o       <= {head_i.hdr[39:32], head_i.hdr[47:40]};
      pad_length_o        <= head_i.hdr[55:48];
      pair_name_length_o  <= nl;
      pair_value_length_o <= vl;
      record_end_o        <= head_i.rend;
      pair_overrun_o      <= ovr;
    end
  end

endmodule
`default_nettype wire

// ----- sv/fastcgi_record_deframer_unit.sv -----
// Top level of the FastCGI record deframer: front end, queue, pair decoder.
// Depends on fcrd_pkg, fcrd_front, fcrd_queue and fcrd_back.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+--------------------------------
//   in      | in        | in_valid_i/in_stall_o | data_byte_i
//   out     | out       | out_valid_o/out_stall_i | class, byte, header, pair fields
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat in and one beat out per clock in steady state while the output is not
// stalled; an accepted byte is framed and written into the queue, then pair-decoded
// and loaded into the output register when it is popped.
// The framing counters and the pair decoder each update once per byte.
// Reset clears framing and pair state and loads the register defaults.
// An output stall holds the result; the queue absorbs QueueDepth bytes before
// in_stall_o rises.
`default_nettype none
module fastcgi_record_deframer_unit #(
  parameter int unsigned QueueDepth = fcrd_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       byte_class_o,
  output logic [7:0]       byte_out_o,
  output logic             header_done_o,
  output logic [7:0]       proto_version_o,
  output logic [7:0]       record_kind_o,
  output logic [15:0]      req_ident_o,
  output logic [15:0]      body_length_o,
  output logic [7:0]       pad_length_o,
  output logic [30:0]      pair_name_length_o,
  output logic [30:0]      pair_value_length_o,
  output logic             record_end_o,
  output logic             pair_overrun_o
);
  import fcrd_pkg::*;

  cfg_wr_t cfg;
  q_stat_t q_stat;
  entry_t  push_entry, head;
  logic    push, pop;

  assign cfg_ready_o = 1'b1;
  assign cfg.wr      = cfg_valid_i && cfg_ready_o;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  fcrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .q_stat_i    (q_stat),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  fcrd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  fcrd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (head),
    .q_stat_i            (q_stat),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .byte_class_o        (byte_class_o),
    .byte_out_o          (byte_out_o),
    .header_done_o       (header_done_o),
    .proto_version_o     (proto_version_o),
    .record_kind_o       (record_kind_o),
    .req_ident_o         (req_ident_o),
    .body_length_o       (body_length_o),
    .pad_length_o        (pad_length_o),
    .pair_name_length_o  (pair_name_length_o),
    .pair_value_length_o (pair_value_length_o),
    .record_end_o        (record_end_o),
    .pair_overrun_o      (pair_overrun_o)
  );

endmodule
`default_nettype wire

// ----- sv/fcrd_checker.sv -----
// Port-level checks on the deframer output, bound to the top level.
// Depends on fcrd_pkg for the byte class codes.
`default_nettype none
module fcrd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  byte_class_o,
  input wire logic [7:0]  byte_out_o,
  input wire logic        header_done_o,
  input wire logic [15:0] body_length_o,
  input wire logic [7:0]  pad_length_o,
  input wire logic [30:0] pair_name_length_o,
  input wire logic        record_end_o,
  input wire logic        pair_overrun_o
);
  import fcrd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_out_o))
    else $error("stalled output beat changed");

  a_hd_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && header_done_o |-> byte_class_o == CLS_HEADER)
    else $error("header_done outside header byte");

  a_empty_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && header_done_o && record_end_o |-> body_length_o == 16'd0 &&
      pad_length_o == 8'd0)
    else $error("record ended on header with nonzero lengths");

  a_ovr_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_overrun_o |-> byte_class_o == CLS_NLEN ||
      byte_class_o == CLS_VLEN || byte_class_o == CLS_NAME || byte_class_o == CLS_VALUE)
    else $error("overrun flagged on non-pair byte");

  a_nlen_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_name_length_o != 31'd0 |-> byte_class_o == CLS_NLEN)
    else $error("name length shown on wrong byte class");

endmodule

bind fastcgi_record_deframer_unit fcrd_checker u_fcrd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .byte_class_o       (byte_class_o),
  .byte_out_o         (byte_out_o),
  .header_done_o      (header_done_o),
  .body_length_o      (body_length_o),
  .pad_length_o       (pad_length_o),
  .pair_name_length_o (pair_name_length_o),
  .record_end_o       (record_end_o),
  .pair_overrun_o     (pair_overrun_o)
);
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for fastcgi_record_deframer_unit: drives FastCGI records byte by byte,
// predicts each output beat in a scoreboard class and compares field by field.
// Depends on fcrd_pkg and the deframer RTL.
module tb_top;
  import fcrd_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned PhaseBytes = 160;

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [2:0] {
    PS_NLEN, PS_NLEN_MORE, PS_VLEN, PS_VLEN_MORE, PS_NAME, PS_VALUE
  } pair_state_e;

  typedef struct packed {
    logic [2:0]  cls;
    logic [7:0]  data;
    logic        hd;
    logic [7:0]  ver;
    logic [7:0]  kind;
    logic [15:0] rid;
    logic [15:0] clen;
    logic [7:0]  plen;
    logic [30:0] nlen;
    logic [30:0] vlen;
    logic        rend;
    logic        ovr;
  } deframe_beat_t;

  class deframe_scoreboard;
    logic [1:0]    frame;
    logic [2:0]    hidx;
    logic [55:0]   hdr;
    logic [15:0]   content_left;
    logic [7:0]    pad_left;
    pair_state_e   pstate;
    logic [30:0]   acc;
    logic [1:0]    acc_left;
    logic [30:0]   name_left;
    logic [30:0]   value_left;
    logic [7:0]    cfg_type;
    logic          cfg_en;
    deframe_beat_t expected_beats[$];
    int            errors;

    function new();
      frame        = FR_HEADER;
      hidx         = '0;
      hdr          = '0;
      content_left = '0;
      pad_left     = '0;
      pstate       = PS_NLEN;
      acc          = '0;
      acc_left     = '0;
      name_left    = '0;
      value_left   = '0;
      cfg_type     = PAIR_TYPE_RESET;
      cfg_en       = PAIR_EN_RESET;
      errors       = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == CFG_PAIR_TYPE) cfg_type = val;
      else if (idx == CFG_PAIR_EN) cfg_en = val[0];
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function pair_state_e after_lengths();
      if (name_left != 0) return PS_NAME;
      if (value_left != 0) return PS_VALUE;
      return PS_NLEN;
    endfunction

    function logic [2:0] pair_byte(logic [7:0] b, output logic [30:0] nl,
                                   output logic [30:0] vl);
      logic       is_v;
      logic [2:0] cls;
      nl = '0;
      vl = '0;
      case (pstate)
        PS_NLEN_MORE, PS_VLEN_MORE: begin
          is_v = (pstate == PS_VLEN_MORE);
          cls = is_v ? CLS_VLEN : CLS_NLEN;
          if (acc_left == 0) acc_left = 2'd1;
          acc = acc | (31'(b) << (8 * (acc_left - 1)));
          acc_left = acc_left - 2'd1;
          if (acc_left == 0) begin
            if (is_v) begin
              value_left = acc;
              vl = acc;
              pstate = after_lengths();
            end else begin
              name_left = acc;
              nl = acc;
              pstate = PS_VLEN;
            end
          end
        end
        PS_NAME: begin
          cls = CLS_NAME;
          if (name_left != 0) name_left = name_left - 1;
          if (name_left == 0) pstate = (value_left != 0) ? PS_VALUE : PS_NLEN;
        end
        PS_VALUE: begin
          cls = CLS_VALUE;
          if (value_left != 0) value_left = value_left - 1;
          if (value_left == 0) pstate = PS_NLEN;
        end
        default: begin
          is_v = (pstate == PS_VLEN);
          cls = is_v ? CLS_VLEN : CLS_NLEN;
          if (b[7]) begin
            acc = {b[6:0], 24'd0};
            acc_left = 2'd3;
            pstate = is_v ? PS_VLEN_MORE : PS_NLEN_MORE;
          end else if (is_v) begin
            value_left = 31'(b);
            vl = 31'(b);
            pstate = after_lengths();
          end else begin
            name_left = 31'(b);
            nl = 31'(b);
            pstate = PS_VLEN;
          end
        end
      endcase
      return cls;
    endfunction

    function void take_byte(logic [7:0] b);
      deframe_beat_t e;
      logic          decode;
      logic [30:0]   nl;
      logic [30:0]   vl;
      e = '0;
      nl = '0;
      vl = '0;
      if (frame == FR_CONTENT) begin
        decode = cfg_en && (hdr[15:8] == cfg_type);
        e.cls = CLS_CONTENT;
        if (decode) e.cls = pair_byte(b, nl, vl);
        if (content_left != 0) content_left = content_left - 1;
        if (content_left == 0) begin
          if (decode && pstate != PS_NLEN) e.ovr = 1'b1;
          if (pad_left != 0) begin
            frame = FR_PADDING;
          end else begin
            e.rend = 1'b1;
            frame = FR_HEADER;
          end
        end
      end else if (frame == FR_PADDING) begin
        e.cls = CLS_PADDING;
        if (pad_left != 0) pad_left = pad_left - 1;
        if (pad_left == 0) begin
          e.rend = 1'b1;
          frame = FR_HEADER;
        end
      end else begin
        e.cls = CLS_HEADER;
        if (hidx < 3'd7) hdr[8*hidx +: 8] = b;
        if (hidx == 3'd7) begin
          e.hd = 1'b1;
          hidx = '0;
          content_left = {hdr[39:32], hdr[47:40]};
          pad_left = hdr[55:48];
          pstate = PS_NLEN;
          acc = '0;
          acc_left = '0;
          name_left = '0;
          value_left = '0;
          if (content_left != 0) begin
            frame = FR_CONTENT;
          end else if (pad_left != 0) begin
            frame = FR_PADDING;
          end else begin
            e.rend = 1'b1;
            frame = FR_HEADER;
          end
        end else begin
          hidx = hidx + 3'd1;
        end
      end
      e.data = b;
      e.ver  = hdr[7:0];
      e.kind = hdr[15:8];
      e.rid  = {hdr[23:16], hdr[31:24]};
      e.clen = {hdr[39:32], hdr[47:40]};
      e.plen = hdr[55:48];
      e.nlen = nl;
      e.vlen = vl;
      expected_beats.insert(expected_beats.size(), e);
    endfunction

    function void match(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void match_beat(deframe_beat_t got);
      deframe_beat_t e;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected, expected none actual byte %0h",
                 $time, got.data);
        return;
      end
      e = expected_beats.pop_front();
      match("byte_class", 32'(e.cls), 32'(got.cls));
      match("byte_out", 32'(e.data), 32'(got.data));
      match("header_done", 32'(e.hd), 32'(got.hd));
      match("proto_version", 32'(e.ver), 32'(got.ver));
      match("record_kind", 32'(e.kind), 32'(got.kind));
      match("req_ident", 32'(e.rid), 32'(got.rid));
      match("body_length", 32'(e.clen), 32'(got.clen));
      match("pad_length", 32'(e.plen), 32'(got.plen));
      match("pair_name_length", 32'(e.nlen), 32'(got.nlen));
      match("pair_value_length", 32'(e.vlen), 32'(got.vlen));
      match("record_end", 32'(e.rend), 32'(got.rend));
      match("pair_overrun", 32'(e.ovr), 32'(got.ovr));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        rx_stall = 1'b0;
  logic        hold_active = 1'b0;
  wire         out_stall = rx_stall | hold_active;

  wire         cfg_ready;
  wire         in_stall;
  wire         out_valid;
  wire [2:0]   byte_class;
  wire [7:0]   byte_out;
  wire         header_done;
  wire [7:0]   proto_version;
  wire [7:0]   record_kind;
  wire [15:0]  req_ident;
  wire [15:0]  body_length;
  wire [7:0]   pad_length;
  wire [30:0]  pair_name_length;
  wire [30:0]  pair_value_length;
  wire         record_end;
  wire         pair_overrun;

  deframe_scoreboard chk;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_kick = 1'b0;
  int          rx_wait = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  fastcgi_record_deframer_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .data_byte_i         (data_byte),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .byte_class_o        (byte_class),
    .byte_out_o          (byte_out),
    .header_done_o       (header_done),
    .proto_version_o     (proto_version),
    .record_kind_o       (record_kind),
    .req_ident_o         (req_ident),
    .body_length_o       (body_length),
    .pad_length_o        (pad_length),
    .pair_name_length_o  (pair_name_length),
    .pair_value_length_o (pair_value_length),
    .record_end_o        (record_end),
    .pair_overrun_o      (pair_overrun)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      chk.match_beat('{cls: byte_class, data: byte_out, hd: header_done,
                       ver: proto_version, kind: record_kind, rid: req_ident,
                       clen: body_length, plen: pad_length, nlen: pair_name_length,
                       vlen: pair_value_length, rend: record_end, ovr: pair_overrun});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) rx_wait = rx_idle ? $urandom_range(0, 12) : 0;
    else if (rx_wait != 0) rx_wait = rx_wait - 1;
    rx_stall <= (rx_wait != 0);
  end

  initial begin
    wait (hold_kick);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** fastcgi_record_deframer_unit: FAILED **");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    chk.take_byte(b);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    chk.set_reg(idx, val);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_record(input logic [7:0] ver, input logic [7:0] kind,
                             input logic [15:0] rid, input byte_q_t body,
                             input logic [7:0] pad_len);
    logic [15:0] clen;
    clen = 16'(body.size());
    push_byte(ver);
    push_byte(kind);
    push_byte(rid[15:8]);
    push_byte(rid[7:0]);
    push_byte(clen[15:8]);
    push_byte(clen[7:0]);
    push_byte(pad_len);
    push_byte(8'($urandom));
    foreach (body[k]) push_byte(body[k]);
    repeat (pad_len) push_byte(8'($urandom));
  endtask

  function automatic byte_q_t random_body(int unsigned n);
    byte_q_t body;
    repeat (n) body.insert(body.size(), 8'($urandom));
    return body;
  endfunction

  // Build well-formed pairs; huge lengths and truncation give overruns.
  function automatic byte_q_t pair_content();
    byte_q_t     body;
    int unsigned pairs;
    int unsigned sel;
    int unsigned cut;
    logic [30:0] ln[2];
    bit          stop;
    stop = 1'b0;
    pairs = $urandom_range(0, 4);
    for (int p = 0; p < pairs && !stop; p++) begin
      for (int k = 0; k < 2; k++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) ln[k] = 31'($urandom);
        else ln[k] = 31'($urandom_range(0, (sel < 3) ? 200 : 5));
        if (sel < 3 || ln[k] > 31'd127) begin
          body.insert(body.size(), {1'b1, ln[k][30:24]});
          body.insert(body.size(), ln[k][23:16]);
          body.insert(body.size(), ln[k][15:8]);
          body.insert(body.size(), ln[k][7:0]);
        end else begin
          body.insert(body.size(), ln[k][7:0]);
        end
      end
      if (32'(ln[0]) + 32'(ln[1]) > 64) begin
        repeat ($urandom_range(0, 8)) body.insert(body.size(), 8'($urandom));
        stop = 1'b1;
      end else begin
        repeat (32'(ln[0]) + 32'(ln[1])) body.insert(body.size(), 8'($urandom));
      end
    end
    if (body.size() != 0 && $urandom_range(0, 5) == 0) begin
      cut = $urandom_range(0, body.size() - 1);
      while (body.size() > cut) void'(body.pop_back());
    end
    return body;
  endfunction

  task automatic send_random_record();
    logic [7:0] kind;
    logic [7:0] pad_len;
    byte_q_t    body;
    if ($urandom_range(0, 9) < 7) kind = chk.cfg_type;
    else kind = 8'($urandom);
    if (kind == chk.cfg_type) body = pair_content();
    else body = random_body($urandom_range(0, 30));
    pad_len = ($urandom_range(0, 11) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    send_record(8'($urandom), kind, 16'($urandom), body, pad_len);
  endtask

  initial begin
    byte_q_t     none;
    byte_q_t     zpair;
    logic [7:0]  ptype[8];
    logic        pen[8];
    int unsigned mark;
    chk = new();
    ptype = '{8'd4, 8'd0, 8'd255, 8'($urandom), 8'd4, 8'($urandom), 8'd255, 8'($urandom)};
    pen   = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    zpair = {8'h00, 8'h00, 8'h81};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0) begin
        wait_drained();
        write_reg(CFG_PAIR_TYPE, ptype[ph]);
        write_reg(CFG_PAIR_EN, {7'd0, pen[ph]});
      end
      tx_idle = (ph != 4);
      rx_idle = (ph != 4);
      mark = bytes_sent;
      if (ph == 0) begin
        send_record(8'hff, 8'h00, 16'hffff, none, 8'd0);
        send_record(8'h01, PAIR_TYPE_RESET, 16'h0000, zpair, 8'd1);
        send_record(8'h01, PAIR_TYPE_RESET, 16'h0001, none, 8'd2);
      end
      if (ph == 2) hold_kick = 1'b1;
      if (ph == 5) send_record(8'h01, chk.cfg_type ^ 8'h01, 16'h1234, random_body(300), 8'd0);
      while (bytes_sent - mark < PhaseBytes) send_random_record();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (chk.errors == 0) begin
      $display("** fastcgi_record_deframer_unit: PASSED **");
    end else begin
      $display("** fastcgi_record_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule
